/* rtl/lbr_pkg.sv */
// Shared types, constants and helpers for the balanced bracket run core.
// No dependencies; imported by lbr_ram users and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lbr_pkg;

  // default store depth (characters per string)
  localparam int unsigned MAX_LEN_DEF = 1024;

  // length added by one matched bracket pair
  localparam int unsigned PAIR_LEN = 2;

  // bracket codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_NONE   = 8'h00;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_symbol;
  } lbr_in_t;

  typedef struct packed {
    logic [10:0] run_here;
    logic [10:0] best_length;
    logic [9:0]  best_start;
    logic        string_done;
    logic        overflow;
  } lbr_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } lbr_state_t;

  // opener matching a closing bracket, CH_NONE for anything else
  function automatic logic [7:0] opener_for(input logic [7:0] c);
    logic [7:0] op;
    op = CH_NONE;
    case (c)
      CH_RPAREN: op = CH_LPAREN;
      CH_RBRACK: op = CH_LBRACK;
      CH_RBRACE: op = CH_LBRACE;
      default:   op = CH_NONE;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

/* rtl/lbr_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/longest_balanced_bracket_run_core.sv */
// Longest balanced bracket run, one character per transfer.
// The store read happens at the input transfer edge; write-back and the output register
//   follow in EXEC, which holds while an earlier result has not been taken.
// No new character is taken before the last one is written back: the data-dependent
//   store read must complete before the run length is written back to the same stores.
// Reset (rst, sync, active high) clears position, best values, flags and handshake
//   state; the character and run stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module longest_balanced_bracket_run_core #(
  parameter int unsigned MAX_LEN = lbr_pkg::MAX_LEN_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire lbr_pkg::lbr_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output lbr_pkg::lbr_out_t     out_data
);

  import lbr_pkg::*;

  localparam int unsigned POS_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_LEN);
  localparam int unsigned RUN_W  = POS_W;

  lbr_state_t state, state_next;

  // string state
  logic [POS_W-1:0]  pos;
  logic [RUN_W-1:0]  best_len;
  logic [ADDR_W-1:0] best_end;
  logic              ovf;
  logic [7:0]        prev_char;
  logic [RUN_W-1:0]  prev_run;
  logic [RUN_W-1:0]  prev2_run;
  lbr_in_t           hold;

  // store ports
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr_char;
  logic [ADDR_W-1:0] rd_addr_run;
  logic [7:0]        rd_char;
  logic [RUN_W-1:0]  rd_run;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;

  logic [POS_W-1:0]  addr_c_full;
  logic [POS_W-1:0]  addr_r_full;

  // run computation
  logic              commit;
  logic              store_ok;
  logic [7:0]        op;
  logic              closer;
  logic              case1;
  logic              case2_ok;
  logic              idx_ge1;
  logic [RUN_W+1:0]  run1_sum;
  logic [RUN_W+1:0]  run2_sum;
  logic [RUN_W-1:0]  run_next;
  logic [RUN_W-1:0]  best_len_next;
  logic [ADDR_W-1:0] best_end_next;
  logic              ovf_next;
  logic [RUN_W:0]    start_sum;
  logic [ADDR_W-1:0] start_next;
  logic [RUN_W+10:0] run_ext;
  logic [RUN_W+10:0] best_ext;
  logic [ADDR_W+9:0] start_ext;

  // look-behind addresses: the char before the previous run, and the run before it
  assign addr_c_full  = pos - prev_run - POS_W'(1);
  assign addr_r_full  = pos - prev_run - POS_W'(PAIR_LEN);
  assign rd_addr_char = addr_c_full[ADDR_W-1:0];
  assign rd_addr_run  = addr_r_full[ADDR_W-1:0];

  lbr_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_char_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (hold.symbol),
    .re    (rd_en),
    .raddr (rd_addr_char),
    .rdata (rd_char)
  );

  lbr_ram #(.WIDTH(RUN_W), .DEPTH(MAX_LEN)) u_run_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (run_next),
    .re    (rd_en),
    .raddr (rd_addr_run),
    .rdata (rd_run)
  );

  // run length for the held character
  always_comb begin
    store_ok = pos < POS_W'(MAX_LEN);
    op       = opener_for(hold.symbol);
    closer   = (op != CH_NONE) && (pos != '0);
    case1    = closer && (prev_char == op);
    case2_ok = closer && !case1 && (prev_run != '0) &&
               (({1'b0, prev_run} + (RUN_W+1)'(1)) <= {1'b0, pos});
    idx_ge1  = ({1'b0, prev_run} + (RUN_W+1)'(PAIR_LEN)) <= {1'b0, pos};
    run1_sum = (RUN_W+2)'(PAIR_LEN) +
               ((pos >= POS_W'(PAIR_LEN)) ? {2'b00, prev2_run} : '0);
    run2_sum = (RUN_W+2)'(PAIR_LEN) + {2'b00, prev_run} +
               (idx_ge1 ? {2'b00, rd_run} : '0);
    run_next = '0;
    if (store_ok) begin
      if (case1) begin
        run_next = run1_sum[RUN_W-1:0];
      end else if (case2_ok && (rd_char == op)) begin
        run_next = run2_sum[RUN_W-1:0];
      end
    end

    // best run; ties keep the earlier one
    best_len_next = best_len;
    best_end_next = best_end;
    if (store_ok && (run_next > best_len)) begin
      best_len_next = run_next;
      best_end_next = pos[ADDR_W-1:0];
    end
    ovf_next = ovf | !store_ok;

    start_sum  = (RUN_W+1)'(best_end_next) + (RUN_W+1)'(1) - {1'b0, best_len_next};
    start_next = (best_len_next != '0) ? start_sum[ADDR_W-1:0] : '0;

    run_ext   = {11'b0, run_next};
    best_ext  = {11'b0, best_len_next};
    start_ext = {10'b0, start_next};
  end

  // control: read on accept, compute and write back in EXEC
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    commit     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_en    = in_valid;
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid || out_ready) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign wr_en   = commit && store_ok;
  assign wr_addr = pos[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // input hold register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= in_data;
    end
  end

  // string state update
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      best_len <= '0;
      best_end <= '0;
      ovf      <= 1'b0;
    end else if (commit) begin
      if (hold.last_symbol) begin
        pos      <= '0;
        best_len <= '0;
        best_end <= '0;
        ovf      <= 1'b0;
      end else begin
        pos      <= store_ok ? pos + POS_W'(1) : pos;
        best_len <= best_len_next;
        best_end <= best_end_next;
        ovf      <= ovf_next;
      end
    end
  end

  // last two positions kept in flops
  always_ff @(posedge clk) begin
    if (wr_en) begin
      prev_char <= hold.symbol;
      prev_run  <= run_next;
      prev2_run <= prev_run;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data.run_here    <= run_ext[10:0];
      out_data.best_length <= best_ext[10:0];
      out_data.best_start  <= start_ext[9:0];
      out_data.string_done <= hold.last_symbol;
      out_data.overflow    <= ovf_next;
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(MAX_LEN))
    else $error("position beyond store depth");

  a_write_in_exec: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_EXEC))
    else $error("store write outside write-back cycle");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new input taken before write-back");

  a_best_covers_run: assert property (@(posedge clk) disable iff (rst)
    commit |-> (best_len_next >= run_next))
    else $error("best length below current run");

  a_best_fits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (best_len <= pos))
    else $error("best run longer than string");
`endif

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for longest_balanced_bracket_run_core: directed strings,
// one string past the store depth, then random strings with random idling on both sides.
// Depends on rtl/lbr_pkg.sv and rtl/longest_balanced_bracket_run_core.sv.
`timescale 1ns / 1ps

module tb_top;
  import lbr_pkg::*;

  localparam int unsigned DEPTH = MAX_LEN_DEF;
  localparam int unsigned RANDOM_SYMBOLS = 650;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 8;

  logic     clk = 1'b0;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  lbr_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  lbr_out_t out_data;

  // expected results, oldest first
  lbr_out_t pending_runs[$];
  int unsigned fail_cnt = 0;
  int unsigned quiet_cycles = 0;

  // no-idle switches for the sender and the receiver
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  // predictor state for the current string
  logic [7:0]  sym_hist [DEPTH];
  logic [10:0] run_hist [DEPTH];
  int unsigned sym_count = 0;
  int unsigned best_len = 0;
  int unsigned best_end = 0;
  logic        over_seen = 1'b0;

  longest_balanced_bracket_run_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // run length ending at this symbol, plus the best run so far
  function automatic lbr_out_t predict_run(input lbr_in_t item);
    lbr_out_t    res;
    logic [7:0]  want;
    int unsigned run;
    int unsigned prev;
    int unsigned idx;
    int unsigned start;
    run = 0;
    start = 0;
    if (sym_count >= DEPTH) begin
      over_seen = 1'b1;
    end else begin
      case (item.symbol)
        CH_RPAREN: want = CH_LPAREN;
        CH_RBRACK: want = CH_LBRACK;
        CH_RBRACE: want = CH_LBRACE;
        default:   want = CH_NONE;
      endcase
      if (want != CH_NONE && sym_count > 0) begin
        if (sym_hist[sym_count - 1] == want) begin
          // closer right after its opener
          run = PAIR_LEN + ((sym_count >= 2) ? run_hist[sym_count - 2] : 0);
        end else if (run_hist[sym_count - 1] > 0) begin
          // look past the run that ends at the previous symbol
          prev = run_hist[sym_count - 1];
          if (prev + 1 <= sym_count) begin
            idx = sym_count - prev - 1;
            if (sym_hist[idx] == want)
              run = PAIR_LEN + prev + ((idx >= 1) ? run_hist[idx - 1] : 0);
          end
        end
      end
      sym_hist[sym_count] = item.symbol;
      run_hist[sym_count] = run[10:0];
      // ties keep the earlier run
      if (run > best_len) begin
        best_len = run;
        best_end = sym_count;
      end
      sym_count++;
    end
    if (best_len > 0 && best_end + 1 >= best_len)
      start = best_end + 1 - best_len;
    res.run_here    = run[10:0];
    res.best_length = best_len[10:0];
    res.best_start  = start[9:0];
    res.string_done = item.last_symbol;
    res.overflow    = over_seen;
    // end of string clears everything but the stores
    if (item.last_symbol) begin
      sym_count = 0;
      best_len = 0;
      best_end = 0;
      over_seen = 1'b0;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [10:0] want,
                             input logic [10:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // scoreboard: check each result transfer, then predict each input transfer
  always @(posedge clk) begin : scoreboard
    lbr_out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_runs.size() == 0) begin
          $error("result transfer with nothing expected: %h", out_data);
          fail_cnt++;
        end else begin
          want = pending_runs.pop_front();
          check_field("run_here", want.run_here, out_data.run_here);
          check_field("best_length", want.best_length, out_data.best_length);
          check_field("best_start", {1'b0, want.best_start}, {1'b0, out_data.best_start});
          check_field("string_done", {10'd0, want.string_done},
                      {10'd0, out_data.string_done});
          check_field("overflow", {10'd0, want.overflow}, {10'd0, out_data.overflow});
        end
      end
      if (in_valid && in_ready)
        pending_runs.push_back(predict_run(in_data));
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // receiver: random stall before each result
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = rx_quiet ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // one symbol transfer after a random gap; returns at the accepting edge
  task automatic send_symbol(input logic [7:0] sym, input logic fin);
    int unsigned gap;
    lbr_in_t     item;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    item.symbol = sym;
    item.last_symbol = fin;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic send_string(input string s);
    for (int k = 0; k < s.len(); k++)
      send_symbol(s[k], k == s.len() - 1);
  endtask

  task automatic hold_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // ( ) [ ] { } in that order: openers even, closers odd
  function automatic logic [7:0] any_bracket(input int unsigned n);
    case (n)
      0:       return CH_LPAREN;
      1:       return CH_RPAREN;
      2:       return CH_LBRACK;
      3:       return CH_RBRACK;
      4:       return CH_LBRACE;
      default: return CH_RBRACE;
    endcase
  endfunction

  task automatic test_directed();
    send_string("()");
    send_string("{[]}");
    // equal-length later run, then a run that swallows an earlier one
    send_string("()(())");
    send_string("([)]");
    // run at the previous symbol reaches back past position zero
    send_string("())");
    send_symbol(8'hFF, 1'b0);
    send_symbol(CH_LBRACE, 1'b0);
    send_symbol(CH_RBRACE, 1'b0);
    send_symbol(8'h00, 1'b1);
    send_string(")");
  endtask

  // fills the store with one run of full length, then runs past the end
  task automatic test_long_string();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    for (int k = 0; k < DEPTH; k++)
      send_symbol((k % 2 == 0) ? CH_LPAREN : CH_RPAREN, 1'b0);
    send_symbol(CH_RPAREN, 1'b0);
    send_symbol(CH_LPAREN, 1'b0);
    // final symbol is dropped too, state must still clear
    send_symbol(CH_RBRACE, 1'b1);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    send_string("[]");
  endtask

  // sender waits until every expected result is out
  task automatic test_drain_pause();
    hold_input();
    while (pending_runs.size() != 0) @(posedge clk);
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned len;
    bit          well_formed;
    bit          paused;
    int unsigned opens[$];
    logic [7:0]  sym;
    sent = 0;
    paused = 1'b0;
    while (sent < RANDOM_SYMBOLS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
      well_formed = ($urandom_range(0, 3) != 0);
      tx_quiet = ($urandom_range(0, 5) == 0);
      rx_quiet = tx_quiet;
      opens.delete();
      for (int k = 0; k < len; k++) begin
        if (!well_formed) begin
          // noise: raw bytes mixed with loose brackets
          sym = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                     : any_bracket($urandom_range(0, 5));
        end else if (opens.size() == 0 ||
                     (opens.size() < len - k - 1 && $urandom_range(0, 1))) begin
          opens.push_back($urandom_range(0, 2));
          sym = any_bracket(2 * opens[$]);
        end else begin
          sym = any_bracket(2 * opens.pop_back() + 1);
          // occasional break in an otherwise nested sequence
          if ($urandom_range(0, 11) == 0)
            sym = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                       : any_bracket($urandom_range(0, 5));
        end
        send_symbol(sym, k == len - 1);
        sent++;
      end
      if (!paused && sent >= RANDOM_SYMBOLS / 2) begin
        paused = 1'b1;
        test_drain_pause();
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_long_string();
    test_random();
    hold_input();
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/lbr_pkg.sv
rtl/lbr_ram.sv
rtl/longest_balanced_bracket_run_core.sv
test/tb_top.sv
